### rtl/core/shifted_sprite_blitter_macros.svh
// Assertion macros for the shifted sprite blitter checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef SHIFTED_SPRITE_BLITTER_MACROS_SVH
`define SHIFTED_SPRITE_BLITTER_MACROS_SVH

// Plain clocked assertion, disabled during reset.
`define SSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A stalled transaction keeps valid high and its payload unchanged.
`define SSB_ASSERT_HOLD(lbl, vld, rdy, data, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(data))) else $error(msg);

`endif

### rtl/core/ssb_pkg.sv
// Shared types and constants for the shifted sprite blitter.
// No dependencies.
package ssb_pkg;

  localparam int ROW_BYTES    = 30;
  localparam int PLANE_BYTES  = 3840;
  localparam int ADDR_W       = 12;
  localparam int ROW_ADDR_W   = 13;
  localparam int ROW_ADDR_MAX = 8191;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  localparam logic [1:0] ROP_OR       = 2'd0;
  localparam logic [1:0] ROP_AND      = 2'd1;
  localparam logic [1:0] ROP_XOR      = 2'd2;
  localparam logic [1:0] ROP_RESERVED = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] x_pos;
    logic [6:0] y_pos;
    logic [7:0] row_count;
    logic [4:0] byte_width;
    logic [1:0] raster_op;
    logic       plane_select;
    logic [7:0] sprite_byte;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic              write_plane;
    logic [7:0]        write_value;
    logic [1:0]        write_op;
    logic              outside_plane;
    logic              last_of_blit;
  } out_t;

  // Results produced by one accepted transaction.
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } res_t;

endpackage

### rtl/core/ssb_engine.sv
// Blit state and shift-merge datapath: turns one accepted transaction into
// up to two byte writes. Depends on ssb_pkg.
module ssb_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  ssb_pkg::in_t in_i,
  output ssb_pkg::res_t res_o
);

  logic [2:0]                     shift_q, shift_d;
  logic [1:0]                     op_q, op_d;
  logic                           plane_q, plane_d;
  logic [ssb_pkg::ROW_ADDR_W-1:0] row_addr_q, row_addr_d;
  logic [4:0]                     col_q, col_d;
  logic [4:0]                     width_q, width_d;
  logic [7:0]                     rows_q, rows_d;
  logic [7:0]                     prev_q, prev_d;
  logic                           active_q, active_d;

  logic [13:0] start_addr, next_row, addr_main, addr_spill;
  logic [7:0]  carry, val_main, val_spill, rows_dec;
  logic [15:0] main_sh, spill_sh;
  logic        last_col;
  logic [ssb_pkg::ADDR_W:0] clip_main, clip_spill;

  function automatic logic [ssb_pkg::ADDR_W:0] clip_addr(logic [13:0] a);
    if (a > 14'(ssb_pkg::PLANE_BYTES - 1)) begin
      return {1'b1, ssb_pkg::ADDR_W'(ssb_pkg::PLANE_BYTES - 1)};
    end
    return {1'b0, a[ssb_pkg::ADDR_W-1:0]};
  endfunction

  always_comb begin
    start_addr = 14'(in_i.y_pos) * 14'(ssb_pkg::ROW_BYTES) + 14'(in_i.x_pos[7:3]);
    next_row   = {1'b0, row_addr_q} + 14'(ssb_pkg::ROW_BYTES);
    addr_main  = {1'b0, row_addr_q} + 14'(col_q);
    addr_spill = {1'b0, row_addr_q} + 14'(width_q);
    last_col   = ({1'b0, col_q} + 6'd1) >= {1'b0, width_q};
    rows_dec   = rows_q - 8'd1;

    if (col_q == '0) begin
      carry = (op_q == ssb_pkg::ROP_AND) ? 8'hff : 8'h00;
    end else begin
      carry = prev_q;
    end
    main_sh   = {carry, in_i.sprite_byte} >> shift_q;
    val_main  = main_sh[7:0];
    spill_sh  = {in_i.sprite_byte, 8'h00} >> shift_q;
    val_spill = spill_sh[7:0];
    if (op_q == ssb_pkg::ROP_AND) begin
      val_spill = val_spill | (8'hff >> shift_q);
    end
    clip_main  = clip_addr(addr_main);
    clip_spill = clip_addr(addr_spill);
  end

  always_comb begin
    res_o.first.write_address  = clip_main[ssb_pkg::ADDR_W-1:0];
    res_o.first.write_plane    = plane_q;
    res_o.first.write_value    = val_main;
    res_o.first.write_op       = op_q;
    res_o.first.outside_plane  = clip_main[ssb_pkg::ADDR_W];
    res_o.first.last_of_blit   = 1'b0;
    res_o.second.write_address = clip_spill[ssb_pkg::ADDR_W-1:0];
    res_o.second.write_plane   = plane_q;
    res_o.second.write_value   = val_spill;
    res_o.second.write_op      = op_q;
    res_o.second.outside_plane = clip_spill[ssb_pkg::ADDR_W];
    res_o.second.last_of_blit  = (rows_dec == '0);
    res_o.count                = 2'd0;
    if (fire_i && (in_i.req_type == ssb_pkg::REQ_DATA) && active_q) begin
      res_o.count = last_col ? 2'd2 : 2'd1;
    end
  end

  always_comb begin
    shift_d    = shift_q;
    op_d       = op_q;
    plane_d    = plane_q;
    row_addr_d = row_addr_q;
    col_d      = col_q;
    width_d    = width_q;
    rows_d     = rows_q;
    prev_d     = prev_q;
    active_d   = active_q;
    if (fire_i && (in_i.req_type == ssb_pkg::REQ_START)) begin
      shift_d    = in_i.x_pos[2:0];
      op_d       = in_i.raster_op;
      plane_d    = in_i.plane_select;
      row_addr_d = (start_addr > 14'(ssb_pkg::ROW_ADDR_MAX)) ?
                   ssb_pkg::ROW_ADDR_W'(ssb_pkg::ROW_ADDR_MAX) :
                   start_addr[ssb_pkg::ROW_ADDR_W-1:0];
      col_d      = '0;
      width_d    = (in_i.byte_width == '0) ? 5'd1 : in_i.byte_width;
      rows_d     = in_i.row_count;
      prev_d     = '0;
      active_d   = (in_i.row_count != '0) && (in_i.raster_op != ssb_pkg::ROP_RESERVED);
    end else if (fire_i && active_q) begin
      prev_d = in_i.sprite_byte;
      if (last_col) begin
        rows_d     = rows_dec;
        row_addr_d = (next_row > 14'(ssb_pkg::ROW_ADDR_MAX)) ?
                     ssb_pkg::ROW_ADDR_W'(ssb_pkg::ROW_ADDR_MAX) :
                     next_row[ssb_pkg::ROW_ADDR_W-1:0];
        col_d      = '0;
        if (rows_dec == '0) begin
          active_d = 1'b0;
        end
      end else begin
        col_d = col_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q    <= '0;
      op_q       <= '0;
      plane_q    <= '0;
      row_addr_q <= '0;
      col_q      <= '0;
      width_q    <= '0;
      rows_q     <= '0;
      prev_q     <= '0;
      active_q   <= 1'b0;
    end else begin
      shift_q    <= shift_d;
      op_q       <= op_d;
      plane_q    <= plane_d;
      row_addr_q <= row_addr_d;
      col_q      <= col_d;
      width_q    <= width_d;
      rows_q     <= rows_d;
      prev_q     <= prev_d;
      active_q   <= active_d;
    end
  end

endmodule

### rtl/core/ssb_outq.sv
// Three-slot result queue that registers the engine's writes and drives
// the output channel. Depends on ssb_pkg.
module ssb_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ssb_pkg::res_t res_i,
  output logic          space_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ssb_pkg::out_t out_data_o
);

  ssb_pkg::out_t slots_q [3];
  ssb_pkg::out_t slots_d [3];
  logic [1:0]    cnt_q, cnt_d, cnt_pop;
  logic          pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = slots_q[0];
  assign space_o     = (cnt_q <= 2'd1);
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    slots_d = slots_q;
    cnt_pop = cnt_q - 2'(pop);
    if (pop) begin
      slots_d[0] = slots_q[1];
      slots_d[1] = slots_q[2];
    end
    if (res_i.count != '0) begin
      case (cnt_pop)
        2'd0: begin
          slots_d[0] = res_i.first;
          slots_d[1] = res_i.second;
        end
        2'd1: begin
          slots_d[1] = res_i.first;
          slots_d[2] = res_i.second;
        end
        default: ;
      endcase
    end
    cnt_d = cnt_pop + res_i.count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slots_q <= slots_d;
  end

endmodule

### rtl/core/shifted_sprite_blitter.sv
// A data transaction's first write is registered in the result queue and reaches the output in the cycle
// after it is accepted when the queue is empty; a row's spill write follows it from the next queue slot.
// Throughput: one transaction per cycle while the result queue has room; a row's last byte yields
// two writes, so the three-slot result queue holds input off at each row end.
// Reset (async, active low) idles the blit state and empties the result queue.
// Top level of the shifted sprite blitter. Depends on ssb_pkg, ssb_engine, ssb_outq.
module shifted_sprite_blitter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ssb_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ssb_pkg::out_t out_data_o
);

  ssb_pkg::res_t res;
  logic          fire;

  assign fire = in_valid_i && in_ready_o;

  ssb_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .in_i   (in_data_i),
    .res_o  (res)
  );

  ssb_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/core/ssb_checker.sv
// Port-level assertions for the shifted sprite blitter, bound to the top level.
// Depends on ssb_pkg and shifted_sprite_blitter_macros.svh.
`include "shifted_sprite_blitter_macros.svh"

module ssb_port_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ssb_pkg::out_t out_data_o
);

  `SSB_ASSERT_HOLD(a_out_hold, out_valid_o, out_ready_i, out_data_o,
                   "stalled transaction changed")
  `SSB_ASSERT(a_op_valid,
              out_valid_o |-> (out_data_o.write_op != ssb_pkg::ROP_RESERVED),
              "reserved op emitted")
  `SSB_ASSERT(a_addr_range,
              out_valid_o |-> (out_data_o.write_address <= 12'(ssb_pkg::PLANE_BYTES - 1)),
              "address past plane end")
  `SSB_ASSERT(a_clip_addr,
              (out_valid_o && out_data_o.outside_plane) |->
              (out_data_o.write_address == 12'(ssb_pkg::PLANE_BYTES - 1)),
              "clipped address not saturated")
  `SSB_ASSERT(a_ready_empty, !out_valid_o |-> in_ready_o, "input stalled with empty queue")

endmodule

bind shifted_sprite_blitter ssb_port_checker u_ssb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
